/* rtl/core/gtc_pkg.sv */
// gtc_pkg: shared widths, codes and state type of the graph triangle counter
// used by graph_triangle_counter and gtc_checker; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package gtc_pkg;

  localparam int unsigned MAX_VERTICES_DEF = 64;
  localparam int unsigned VERTEX_W         = 6;
  localparam int unsigned VCOUNT_W         = 7;
  localparam int unsigned COUNT_W          = 18;
  localparam int unsigned DATA_W           = 32;
  localparam int unsigned ADDR_W           = 3;
  localparam int unsigned POP_W            = 64;

  localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 7'd64;
  // word index of the vertex count register (paddr[2])
  localparam logic REG_IDX_VCOUNT = 1'b0;

  typedef enum logic [1:0] {
    ACT_ADD    = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_QUERY  = 2'd2,
    ACT_COUNT  = 2'd3
  } action_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EDIT_A,
    ST_EDIT_B,
    ST_QUERY,
    ST_CNT_ROW,
    ST_CNT_NB,
    ST_CNT_SCAN,
    ST_CNT_DRAIN,
    ST_DONE
  } state_e;

endpackage

`default_nettype wire

/* rtl/core/graph_triangle_counter.sv */
// graph_triangle_counter: adjacency bit matrix in a synchronous memory with
// edge add, remove, query and ordered triangle count; depends on gtc_pkg
`timescale 1ns / 1ps
`default_nettype none

// Keeps an undirected graph of up to MAX_VERTICES vertices as one row of
// adjacency bits per vertex in a single memory (one write port, two read
// ports, registered read data). Rows hold zero after reset through a valid
// bit per row, so no clearing pass is needed and the block takes a request
// straight after reset. One request is worked on at a time, and a finished
// result sits in the output register while the next request is taken.
// Steps from the accepting edge to the result being loaded into the output
// register: a flagged request goes straight to the result, a query reads
// both rows, an add or remove reads both rows, writes row a, writes row b,
// and a triangle count walks the rows for the effective vertex count n:
// for each vertex u one read of row u, one step to latch it, then one read
// of every row v through the second read port, with a registered popcount
// and an accumulate behind it; the pipeline is drained before the next u.
// A count with zero vertices goes straight to the result. The result is
// loaded once the output register is free. The vertex count register is
// written through the APB port at byte address 0 and should only be changed
// while no request is in flight.
module graph_triangle_counter
  import gtc_pkg::*;
#(
  parameter int unsigned MAX_VERTICES = MAX_VERTICES_DEF
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  // configuration port
  input  wire                 psel,
  input  wire                 penable,
  input  wire                 pwrite,
  input  wire  [ADDR_W-1:0]   paddr,
  input  wire  [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]   prdata,
  output logic                pready,
  // request channel
  input  wire                 in_valid_i,
  output logic                in_stall_o,
  input  wire  [1:0]          action_i,
  input  wire  [VERTEX_W-1:0] vertex_a_i,
  input  wire  [VERTEX_W-1:0] vertex_b_i,
  // result channel
  output logic                out_valid_o,
  input  wire                 out_stall_i,
  output logic                edge_present_o,
  output logic [COUNT_W-1:0]  triangle_count_o,
  output logic                bad_vertex_o
);

  localparam int unsigned VW    = $clog2(MAX_VERTICES);
  localparam int unsigned ROW_W = MAX_VERTICES;
  localparam int unsigned PC_W  = $clog2(MAX_VERTICES + 1);

  // popcount of a padded row, swar style, six narrow steps
  function automatic logic [PC_W-1:0] row_popcount(input logic [POP_W-1:0] x);
    logic [POP_W-1:0] s1;
    logic [POP_W-1:0] s2;
    logic [POP_W-1:0] s3;
    logic [POP_W-1:0] s4;
    logic [POP_W-1:0] s5;
    logic [POP_W-1:0] s6;
    s1 = x - ((x >> 1) & 64'h5555_5555_5555_5555);
    s2 = (s1 & 64'h3333_3333_3333_3333) + ((s1 >> 2) & 64'h3333_3333_3333_3333);
    s3 = (s2 + (s2 >> 4)) & 64'h0f0f_0f0f_0f0f_0f0f;
    s4 = s3 + (s3 >> 8);
    s5 = s4 + (s4 >> 16);
    s6 = s5 + (s5 >> 32);
    return PC_W'(s6[6:0]);
  endfunction

  // ---------------------------------------------------------------------------
  // configuration register
  // ---------------------------------------------------------------------------
  logic [VCOUNT_W-1:0] vcount_q;
  logic                cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready &&
                     (paddr[ADDR_W-1:2] == REG_IDX_VCOUNT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q <= VCOUNT_RESET;
    end else if (cfg_write) begin
      vcount_q <= pwdata[VCOUNT_W-1:0];
    end
  end

  always_comb begin
    if (paddr[ADDR_W-1:2] == REG_IDX_VCOUNT) begin
      prdata = DATA_W'(vcount_q);
    end else begin
      prdata = '0;
    end
  end

  // effective vertex count, clipped to what the memory holds
  logic [VCOUNT_W-1:0] n_eff;
  logic [VCOUNT_W-1:0] n_last;
  logic [ROW_W-1:0]    live_mask;

  assign n_eff  = (vcount_q > VCOUNT_W'(MAX_VERTICES)) ? VCOUNT_W'(MAX_VERTICES) : vcount_q;
  assign n_last = n_eff - VCOUNT_W'(1);

  always_comb begin
    for (int i = 0; i < MAX_VERTICES; i++) begin
      live_mask[i] = (VCOUNT_W'(i) < n_eff);
    end
  end

  // ---------------------------------------------------------------------------
  // request decode
  // ---------------------------------------------------------------------------
  state_e state_q;
  state_e state_d;

  logic in_accept;
  logic req_bad;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;

  // endpoint past the live range, or a self loop
  assign req_bad = ({1'b0, vertex_a_i} >= n_eff) || ({1'b0, vertex_b_i} >= n_eff) ||
                   (vertex_a_i == vertex_b_i);

  // captured request
  action_e       act_q;
  logic [VW-1:0] a_q;
  logic [VW-1:0] b_q;
  logic          res_bad_q;
  logic          res_present_q;

  // count walk
  logic [VW-1:0]    u_q;
  logic [VW-1:0]    v_q;
  logic [ROW_W-1:0] nb_q;
  logic             u_last;
  logic             v_last;

  assign u_last = (VCOUNT_W'(u_q) == n_last);
  assign v_last = (VCOUNT_W'(v_q) == n_last);

  // scan pipeline: read issued, data back, popcount registered
  logic                scan_v_q;
  logic [VW-1:0]       v_p1_q;
  logic                pop_v_q;
  logic [PC_W-1:0]     pop_q;
  logic [COUNT_W-1:0]  acc_q;
  logic                drained;

  assign drained = !scan_v_q && !pop_v_q;

  // output slot can take a result this cycle
  logic out_free;
  assign out_free = !out_valid_o || !out_stall_i;

  // ---------------------------------------------------------------------------
  // memory side signals
  // ---------------------------------------------------------------------------
  logic             rd_a_en;
  logic [VW-1:0]    rd_a_addr;
  logic             rd_b_en;
  logic [VW-1:0]    rd_b_addr;
  logic             mem_we;
  logic [VW-1:0]    mem_wa;
  logic [ROW_W-1:0] mem_wd;

  logic [ROW_W-1:0] rd_a_raw_q;
  logic [ROW_W-1:0] rd_b_raw_q;
  logic             rdv_a_q;
  logic             rdv_b_q;
  logic [ROW_W-1:0] rd_a;
  logic [ROW_W-1:0] rd_b;

  // rows never written read as empty
  assign rd_a = rd_a_raw_q & {ROW_W{rdv_a_q}};
  assign rd_b = rd_b_raw_q & {ROW_W{rdv_b_q}};

  // control strobes
  logic req_load;
  logic nb_load;
  logic scan_issue;
  logic u_inc;
  logic pres_load;
  logic out_load;

  // ---------------------------------------------------------------------------
  // state machine: next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          if (action_e'(action_i) == ACT_COUNT) begin
            state_d = (n_eff == '0) ? ST_DONE : ST_CNT_ROW;
          end else if (req_bad) begin
            state_d = ST_DONE;
          end else if (action_e'(action_i) == ACT_QUERY) begin
            state_d = ST_QUERY;
          end else begin
            state_d = ST_EDIT_A;
          end
        end
      end
      ST_EDIT_A:  state_d = ST_EDIT_B;
      ST_EDIT_B:  state_d = ST_DONE;
      ST_QUERY:   state_d = ST_DONE;
      ST_CNT_ROW: state_d = ST_CNT_NB;
      ST_CNT_NB:  state_d = ST_CNT_SCAN;
      ST_CNT_SCAN: begin
        if (v_last) begin
          state_d = ST_CNT_DRAIN;
        end
      end
      ST_CNT_DRAIN: begin
        if (drained) begin
          state_d = u_last ? ST_DONE : ST_CNT_ROW;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // state machine: outputs
  // ---------------------------------------------------------------------------
  always_comb begin
    req_load   = 1'b0;
    nb_load    = 1'b0;
    scan_issue = 1'b0;
    u_inc      = 1'b0;
    pres_load  = 1'b0;
    out_load   = 1'b0;
    rd_a_en    = 1'b0;
    rd_a_addr  = u_q;
    rd_b_en    = 1'b0;
    rd_b_addr  = v_q;
    mem_we     = 1'b0;
    mem_wa     = a_q;
    mem_wd     = rd_a;
    unique case (state_q)
      ST_IDLE: begin
        // rows a and b are fetched on every request, used only by edits and queries
        if (in_accept) begin
          req_load  = 1'b1;
          rd_a_en   = 1'b1;
          rd_a_addr = vertex_a_i[VW-1:0];
          rd_b_en   = 1'b1;
          rd_b_addr = vertex_b_i[VW-1:0];
        end
      end
      ST_EDIT_A: begin
        mem_we = 1'b1;
        mem_wa = a_q;
        if (act_q == ACT_ADD) begin
          mem_wd = rd_a | (ROW_W'(1) << b_q);
        end else begin
          mem_wd = rd_a & ~(ROW_W'(1) << b_q);
        end
      end
      ST_EDIT_B: begin
        mem_we = 1'b1;
        mem_wa = b_q;
        if (act_q == ACT_ADD) begin
          mem_wd = rd_b | (ROW_W'(1) << a_q);
        end else begin
          mem_wd = rd_b & ~(ROW_W'(1) << a_q);
        end
      end
      ST_QUERY: begin
        pres_load = 1'b1;
      end
      ST_CNT_ROW: begin
        rd_a_en   = 1'b1;
        rd_a_addr = u_q;
      end
      ST_CNT_NB: begin
        nb_load = 1'b1;
      end
      ST_CNT_SCAN: begin
        rd_b_en    = 1'b1;
        rd_b_addr  = v_q;
        scan_issue = 1'b1;
      end
      ST_CNT_DRAIN: begin
        u_inc = drained && !u_last;
      end
      ST_DONE: begin
        out_load = out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // ---------------------------------------------------------------------------
  // adjacency memory, one row per vertex
  // ---------------------------------------------------------------------------
  logic [ROW_W-1:0] adj_mem [MAX_VERTICES];
  logic [ROW_W-1:0] row_valid_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      adj_mem[mem_wa] <= mem_wd;
    end
    if (rd_a_en) begin
      rd_a_raw_q <= adj_mem[rd_a_addr];
    end
    if (rd_b_en) begin
      rd_b_raw_q <= adj_mem[rd_b_addr];
    end
  end

  // per row valid bits stand in for clearing the memory at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_valid_q <= '0;
      rdv_a_q     <= 1'b0;
      rdv_b_q     <= 1'b0;
    end else begin
      if (mem_we) begin
        row_valid_q[mem_wa] <= 1'b1;
      end
      if (rd_a_en) begin
        rdv_a_q <= row_valid_q[rd_a_addr];
      end
      if (rd_b_en) begin
        rdv_b_q <= row_valid_q[rd_b_addr];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // request capture and query result
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (req_load) begin
      act_q     <= action_e'(action_i);
      a_q       <= vertex_a_i[VW-1:0];
      b_q       <= vertex_b_i[VW-1:0];
      res_bad_q <= (action_e'(action_i) != ACT_COUNT) && req_bad;
    end
    if (req_load) begin
      res_present_q <= 1'b0;
    end else if (pres_load) begin
      res_present_q <= rd_a[b_q];
    end
  end

  // ---------------------------------------------------------------------------
  // triangle count walk
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      u_q      <= '0;
      v_q      <= '0;
      scan_v_q <= 1'b0;
      pop_v_q  <= 1'b0;
    end else begin
      if (req_load) begin
        u_q <= '0;
      end else if (u_inc) begin
        u_q <= u_q + VW'(1);
      end
      if (nb_load) begin
        v_q <= '0;
      end else if (scan_issue) begin
        v_q <= v_q + VW'(1);
      end
      scan_v_q <= scan_issue;
      pop_v_q  <= scan_v_q;
    end
  end

  logic [POP_W-1:0] common_pad;

  // common neighbours of u and v, only counted where v is a neighbour of u
  always_comb begin
    common_pad              = '0;
    common_pad[ROW_W-1:0]   = nb_q & rd_b;
  end

  always_ff @(posedge clk_i) begin
    if (nb_load) begin
      nb_q <= rd_a & live_mask;
    end
    if (scan_issue) begin
      v_p1_q <= v_q;
    end
    if (scan_v_q) begin
      pop_q <= nb_q[v_p1_q] ? row_popcount(common_pad) : '0;
    end
    if (req_load) begin
      acc_q <= '0;
    end else if (pop_v_q) begin
      acc_q <= acc_q + COUNT_W'(pop_q);
    end
  end

  // ---------------------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (out_load) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      edge_present_o   <= res_present_q;
      triangle_count_o <= acc_q;
      bad_vertex_o     <= res_bad_q;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/gtc_checker.sv */
// gtc_checker: port level assertions for graph_triangle_counter, with bind
// depends on gtc_pkg and the top level port list
`timescale 1ns / 1ps
`default_nettype none

module gtc_checker
  import gtc_pkg::*;
(
  input wire               clk_i,
  input wire               rst_ni,
  input wire               in_valid_i,
  input wire               in_stall_o,
  input wire               out_valid_o,
  input wire               out_stall_i,
  input wire               edge_present_o,
  input wire [COUNT_W-1:0] triangle_count_o,
  input wire               bad_vertex_o
);

  // held result does not change while stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(edge_present_o) &&
    $stable(triangle_count_o) && $stable(bad_vertex_o))
    else $error("stalled result changed");

  // one request at a time: busy right after a request is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request taken while busy");

  // flagged requests report nothing else
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bad_vertex_o |-> !edge_present_o && (triangle_count_o == '0))
    else $error("flagged result carries data");

  // ordered count is even and never shares a result with an edge hit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !triangle_count_o[0] &&
    !(edge_present_o && (triangle_count_o != '0)))
    else $error("inconsistent count result");

endmodule

bind graph_triangle_counter gtc_checker u_gtc_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_stall_o       (in_stall_o),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .edge_present_o   (edge_present_o),
  .triangle_count_o (triangle_count_o),
  .bad_vertex_o     (bad_vertex_o)
);

`default_nettype wire

/* tb/tb_graph_triangle_counter.sv */
// tb_graph_triangle_counter: self-checking testbench for the graph triangle counter
// drives edits, queries and counts with random idling on both channels
// depends on gtc_pkg and graph_triangle_counter
`timescale 1ns / 1ps

module tb_graph_triangle_counter;
  import gtc_pkg::*;

  // generous cycle limit, the slowest legal run stays well below it
  localparam int unsigned CYCLE_LIMIT = 4_000_000;

  typedef struct packed {
    logic               edge_present;
    logic [COUNT_W-1:0] triangle_count;
    logic               bad_vertex;
  } gtc_result_t;

  // clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // configuration port
  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [ADDR_W-1:0] paddr   = '0;
  logic [DATA_W-1:0] pwdata  = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  // request channel
  logic                in_valid = 1'b0;
  logic                in_stall;
  action_e             req_action = ACT_ADD;
  logic [VERTEX_W-1:0] req_vertex_a = '0;
  logic [VERTEX_W-1:0] req_vertex_b = '0;

  // result channel
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               res_edge_present;
  logic [COUNT_W-1:0] res_triangle_count;
  logic               res_bad_vertex;

  // predictor state: adjacency rows and the vertex count register
  logic [63:0]         graph_rows [MAX_VERTICES_DEF];
  logic [VCOUNT_W-1:0] vcount_reg = VCOUNT_RESET;

  gtc_result_t    pending_results [$];
  int unsigned    error_count = 0;
  int unsigned    cycle_count = 0;
  int unsigned    in_gap_max  = 5;
  int unsigned    out_gap_max = 5;
  int unsigned    stall_left  = 0;

  graph_triangle_counter #(
    .MAX_VERTICES(MAX_VERTICES_DEF)
  ) i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .action_i        (req_action),
    .vertex_a_i      (req_vertex_a),
    .vertex_b_i      (req_vertex_b),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .edge_present_o  (res_edge_present),
    .triangle_count_o(res_triangle_count),
    .bad_vertex_o    (res_bad_vertex)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // watchdog: a hung block ends the run as a failure
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_graph_triangle_counter NOT OK");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // register values above the parameter act as the parameter
  function automatic int unsigned effective_vertices();
    if (vcount_reg > MAX_VERTICES_DEF) return MAX_VERTICES_DEF;
    return vcount_reg;
  endfunction

  // ordered count: every adjacent pair (u,v) adds its common neighbours,
  // only vertices below the effective count take part
  function automatic logic [COUNT_W-1:0] ordered_triangles();
    int unsigned n;
    int unsigned sum;
    logic [63:0] live;
    logic [63:0] nbrs;
    n    = effective_vertices();
    live = (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
    sum  = 0;
    for (int unsigned u = 0; u < n; u++) begin
      nbrs = graph_rows[u] & live;
      for (int unsigned v = 0; v < n; v++) begin
        if (nbrs[v]) sum += $countones(nbrs & graph_rows[v]);
      end
    end
    return sum[COUNT_W-1:0];
  endfunction

  // applies one request to the predicted graph and returns its result
  function automatic gtc_result_t predict_request(action_e act, logic [VERTEX_W-1:0] a,
                                                  logic [VERTEX_W-1:0] b);
    gtc_result_t res;
    int unsigned n;
    res = '0;
    n   = effective_vertices();
    if (act == ACT_COUNT) begin
      res.triangle_count = ordered_triangles();
    end else if (a >= n || b >= n || a == b) begin
      // out-of-range endpoint or self-loop: nothing is touched
      res.bad_vertex = 1'b1;
    end else if (act == ACT_ADD) begin
      graph_rows[a][b] = 1'b1;
      graph_rows[b][a] = 1'b1;
    end else if (act == ACT_REMOVE) begin
      graph_rows[a][b] = 1'b0;
      graph_rows[b][a] = 1'b0;
    end else begin
      res.edge_present = graph_rows[a][b];
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // result checker and output stall generator
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    gtc_result_t exp_res;
    if (rst_ni) begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $error("result with no request outstanding");
          error_count++;
        end else begin
          exp_res = pending_results.pop_front();
          if (res_edge_present !== exp_res.edge_present) begin
            $error("edge_present: expected %0d, got %0d", exp_res.edge_present,
                   res_edge_present);
            error_count++;
          end
          if (res_triangle_count !== exp_res.triangle_count) begin
            $error("triangle_count: expected %0d, got %0d", exp_res.triangle_count,
                   res_triangle_count);
            error_count++;
          end
          if (res_bad_vertex !== exp_res.bad_vertex) begin
            $error("bad_vertex: expected %0d, got %0d", exp_res.bad_vertex,
                   res_bad_vertex);
            error_count++;
          end
        end
        // each result draws how long the receiver holds off afterwards
        stall_left = $urandom_range(0, out_gap_max);
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  // sends one request; valid stays high into the next request when no gap
  // is drawn, so it is never lowered and raised in the same step
  task automatic send_request(action_e act, logic [VERTEX_W-1:0] a,
                              logic [VERTEX_W-1:0] b);
    int unsigned gap;
    gap = $urandom_range(0, in_gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid     <= 1'b1;
    req_action   <= act;
    req_vertex_a <= a;
    req_vertex_b <= b;
    do @(posedge clk_i); while (in_stall);
    pending_results.insert(pending_results.size(), predict_request(act, a, b));
  endtask

  // drops valid and waits until every result is back; each request gives
  // exactly one result, so the block is idle then
  task automatic drain_requests();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // setup phase then access phase; pready is always high
  task automatic write_vertex_count(logic [VCOUNT_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_IDX_VCOUNT, 2'b00};
    pwdata  <= DATA_W'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    vcount_reg = value;
  endtask

  // random requests: endpoints mostly in [lo, hi] so edges pile up into
  // triangles, the rest anywhere in the field (bad vertices, self-loops)
  task automatic random_requests(int unsigned num, int unsigned count_pct,
                                 int unsigned lo, int unsigned hi);
    action_e             act;
    logic [VERTEX_W-1:0] a;
    logic [VERTEX_W-1:0] b;
    int unsigned         roll;
    for (int unsigned i = 0; i < num; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < count_pct) act = ACT_COUNT;
      else if (roll < count_pct + 45) act = ACT_ADD;
      else if (roll < count_pct + 63) act = ACT_REMOVE;
      else act = ACT_QUERY;
      if ($urandom_range(0, 99) < 88) begin
        a = VERTEX_W'($urandom_range(lo, hi));
        b = VERTEX_W'($urandom_range(lo, hi));
      end else begin
        a = VERTEX_W'($urandom_range(0, 63));
        b = VERTEX_W'($urandom_range(0, 63));
      end
      send_request(act, a, b);
    end
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // edits, queries and counts at the reset vertex count
  task automatic test_directed_edits();
    send_request(ACT_QUERY, 6'd0, 6'd1);    // empty graph
    send_request(ACT_COUNT, 6'd63, 6'd63);  // empty graph counts zero
    send_request(ACT_ADD, 6'd0, 6'd1);
    send_request(ACT_QUERY, 6'd1, 6'd0);    // reverse direction is set too
    send_request(ACT_ADD, 6'd1, 6'd2);
    send_request(ACT_ADD, 6'd2, 6'd0);
    send_request(ACT_COUNT, 6'd0, 6'd0);    // one triangle, six ordered
    send_request(ACT_ADD, 6'd62, 6'd63);    // top vertices
    send_request(ACT_ADD, 6'd0, 6'd63);
    send_request(ACT_QUERY, 6'd63, 6'd62);
    send_request(ACT_ADD, 6'd5, 6'd5);      // self-loop is flagged
    send_request(ACT_QUERY, 6'd63, 6'd63);  // self-loop query
    send_request(ACT_REMOVE, 6'd1, 6'd0);
    send_request(ACT_QUERY, 6'd0, 6'd1);
    send_request(ACT_REMOVE, 6'd10, 6'd11); // removing a missing edge
    send_request(ACT_ADD, 6'd0, 6'd1);
    send_request(ACT_COUNT, 6'd0, 6'd0);
    drain_requests();
  endtask

  // lowered, zero and oversized vertex counts; stored edges survive
  task automatic test_vertex_count_limits();
    write_vertex_count(7'd3);
    send_request(ACT_QUERY, 6'd62, 6'd63); // above the count, flagged
    send_request(ACT_ADD, 6'd0, 6'd3);     // b equals the count
    send_request(ACT_COUNT, 6'd0, 6'd0);   // only vertices 0..2 seen
    send_request(ACT_REMOVE, 6'd2, 6'd1);
    send_request(ACT_COUNT, 6'd0, 6'd0);
    drain_requests();
    write_vertex_count(7'd0);
    send_request(ACT_ADD, 6'd0, 6'd1);     // every endpoint is bad
    send_request(ACT_COUNT, 6'd0, 6'd0);
    drain_requests();
    write_vertex_count(7'd127);            // acts as the maximum
    send_request(ACT_QUERY, 6'd62, 6'd63); // edge kept across the changes
    send_request(ACT_ADD, 6'd1, 6'd2);
    send_request(ACT_COUNT, 6'd0, 6'd0);
    drain_requests();
    write_vertex_count(7'd1);
    send_request(ACT_QUERY, 6'd0, 6'd0);
    send_request(ACT_COUNT, 6'd0, 6'd0);
    drain_requests();
  endtask

  // many short phases on small graphs, counts are cheap there
  task automatic test_random_small_graphs();
    int unsigned vc;
    for (int unsigned phase = 0; phase < 8; phase++) begin
      vc = $urandom_range(2, 12);
      write_vertex_count(VCOUNT_W'(vc));
      // some phases run with no idling on one of the channels
      in_gap_max  = (phase % 3 == 1) ? 0 : 5;
      out_gap_max = (phase % 4 == 2) ? 0 : 5;
      random_requests(88, 6, 0, vc - 1);
      drain_requests();
    end
  endtask

  // full-size graph with edges clustered in small windows, few counts
  task automatic test_random_full_graph();
    int unsigned base;
    for (int unsigned phase = 0; phase < 2; phase++) begin
      write_vertex_count(phase == 0 ? VCOUNT_W'(64) : VCOUNT_W'(127));
      in_gap_max  = 5;
      out_gap_max = (phase == 1) ? 0 : 5;
      base = $urandom_range(0, 56);
      random_requests(80, 4, base, base + 7);
      drain_requests();
    end
    // one last small setting so the register ends away from the maximum
    write_vertex_count(7'd5);
    random_requests(30, 10, 0, 4);
    drain_requests();
  endtask

  initial begin
    // reset held, then released at a clock edge
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int unsigned i = 0; i < MAX_VERTICES_DEF; i++) graph_rows[i] = '0;

    test_directed_edits();
    test_vertex_count_limits();
    test_random_small_graphs();
    test_random_full_graph();

    repeat (20) @(posedge clk_i);
    if (error_count == 0) begin
      $display("tb_graph_triangle_counter OK");
    end else begin
      $display("tb_graph_triangle_counter NOT OK");
    end
    $finish;
  end

endmodule
